// ----- hdl/rspe_pkg.sv -----
// ----------------------------------------------------------------------------
// rspe_pkg
// Shared constants, types and GF(256) arithmetic for the Reed-Solomon parity
// encoder.
// ----------------------------------------------------------------------------
package rspe_pkg;

   localparam int MAX_PARITY   = 32;
   localparam int RESET_PARITY = 10;
   localparam int CFG_W        = 6;
   localparam int CNT_W        = $clog2(MAX_PARITY + 1);
   localparam int IDX_W        = $clog2(MAX_PARITY);
   localparam int CMP_W        = (CNT_W > CFG_W) ? CNT_W : CFG_W;

   localparam int QUEUE_DEPTH  = 4;
   localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

   // Low byte of the field polynomial x^8+x^4+x^3+x^2+1.
   localparam logic [7:0] GF_POLY_LOW = 8'h1D;
   localparam logic [7:0] GF_ONE      = 8'h01;
   localparam logic [7:0] GF_ALPHA    = 8'h02;

   typedef logic [7:0] gf_byte_type;
   typedef gf_byte_type [MAX_PARITY-1:0] coef_vec_type;

   typedef struct packed {
      gf_byte_type data_byte;
      logic        block_end;
   } item_type;

   typedef struct packed {
      logic             busy;
      logic [CNT_W-1:0] count;
   } gen_stat_type;

   typedef struct packed {
      logic             load;
      logic [IDX_W-1:0] last_index;
   } emit_load_type;

   // Shift-and-add multiply in GF(256).
   function automatic gf_byte_type gf_mul(input gf_byte_type a, input gf_byte_type b);
      gf_byte_type acc;
      gf_byte_type sh;
      logic        carry;
      acc = '0;
      sh  = a;
      for (int k = 0; k < 8; k++) begin
         if (b[k]) begin
            acc = acc ^ sh;
         end
         carry = sh[7];
         sh    = {sh[6:0], 1'b0};
         if (carry) begin
            sh = sh ^ GF_POLY_LOW;
         end
      end
      return acc;
   endfunction

   // A count of zero means one; anything above the maximum saturates.
   function automatic logic [CNT_W-1:0] clamp_count(input logic [CFG_W-1:0] v);
      logic [CMP_W-1:0] w;
      w = CMP_W'(v);
      if (w == '0) begin
         return CNT_W'(1);
      end else if (w > CMP_W'(MAX_PARITY)) begin
         return CNT_W'(MAX_PARITY);
      end else begin
         return CNT_W'(w);
      end
   endfunction

endpackage

// ----- hdl/rspe_if.sv -----
// ----------------------------------------------------------------------------
// rspe channel interfaces
// Valid/ready channels for data requests, parity results and the parity
// count register write.
// ----------------------------------------------------------------------------
interface rspe_req_if import rspe_pkg::*; ();
   logic        valid;
   logic        ready;
   gf_byte_type data_byte;
   logic        block_end;

   modport source (output valid, output data_byte, output block_end, input ready);
   modport sink   (input valid, input data_byte, input block_end, output ready);
endinterface

interface rspe_rsp_if import rspe_pkg::*; ();
   logic        valid;
   logic        ready;
   gf_byte_type parity_byte;
   logic        parity_last;

   modport source (output valid, output parity_byte, output parity_last, input ready);
   modport sink   (input valid, input parity_byte, input parity_last, output ready);
endinterface

interface rspe_csr_if import rspe_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [CFG_W-1:0] parity_count;

   modport source (output valid, output parity_count, input ready);
   modport sink   (input valid, input parity_count, output ready);
endinterface

// ----- hdl/reed_solomon_parity_encoder.sv -----
// ----------------------------------------------------------------------------
// reed_solomon_parity_encoder
// Systematic Reed-Solomon parity encoder over GF(256), field polynomial 0x11D.
// ----------------------------------------------------------------------------
// Data bytes arrive as requests on req_chan, one per cycle at full rate; the
// request with block_end set closes a block, and the n parity bytes of that
// block then leave on rsp_chan, highest degree first, with parity_last on the
// final one. The division register absorbs one byte per clock when not held,
// with one GF multiplier per stage. Parity for a block is moved into an
// output register that drains one byte per cycle while rsp_chan is ready,
// as the next block already streams in; the final byte of the next block
// waits only if the previous block's parity has not yet all been taken. A
// four-entry request queue separates the input handshake from the division
// register. Writing csr_chan sets the parity count n (0 reads as 1, values
// above 32 read as 32; reset sets it to 10), discards any partial block and
// rebuilds the generator polynomial, one root per cycle: while it is being
// rebuilt, after the write and after reset, queued requests are held and
// not yet absorbed. The register is meant to be written only while no block
// is in flight.
module reed_solomon_parity_encoder import rspe_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   rspe_req_if.sink   req_chan,
   rspe_rsp_if.source rsp_chan,
   rspe_csr_if.sink   csr_chan
);

   logic          q_valid;
   item_type      q_item;
   logic          q_pop;
   logic          cfg_wr;
   gen_stat_type  gen_stat;
   coef_vec_type  coef;
   logic          emit_free;
   emit_load_type emit_load;
   coef_vec_type  snap;

   // The register port never stalls; a write simply restarts the build.
   assign csr_chan.ready = 1'b1;
   assign cfg_wr         = csr_chan.valid;

   // Front end: request queue.
   rspe_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_valid  (q_valid),
      .q_item   (q_item),
      .q_pop    (q_pop)
   );

   // Generator builder, run after reset and after every count write.
   rspe_genbuild u_genbuild (
      .clock     (clock),
      .reset     (reset),
      .cfg_wr    (cfg_wr),
      .cfg_value (csr_chan.parity_count),
      .gen_stat  (gen_stat),
      .coef      (coef)
   );

   // Back end: division register followed by the parity output stage.
   rspe_div u_div (
      .clock     (clock),
      .reset     (reset),
      .cfg_wr    (cfg_wr),
      .gen_stat  (gen_stat),
      .coef      (coef),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop),
      .emit_free (emit_free),
      .emit_load (emit_load),
      .snap      (snap)
   );

   rspe_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .emit_load (emit_load),
      .snap      (snap),
      .emit_free (emit_free),
      .rsp_chan  (rsp_chan)
   );

endmodule

// ----- hdl/rspe_front.sv -----
// ----------------------------------------------------------------------------
// rspe_front
// Accepts data requests and holds them in a short queue for the division
// register.
// ----------------------------------------------------------------------------
module rspe_front import rspe_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   rspe_req_if.sink   req_chan,
   output logic       q_valid,
   output item_type   q_item,
   input  logic       q_pop
);

   item_type          mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              push;
   item_type          item_in;

   assign req_chan.ready = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign push           = req_chan.valid && req_chan.ready;
   assign q_valid        = (count_ff != '0);
   assign q_item         = mem_ff[rd_ptr_ff];

   always_comb begin
      item_in.data_byte = req_chan.data_byte;
      item_in.block_end = req_chan.block_end;

      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (q_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, q_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= item_in;
      end
   end

endmodule

// ----- hdl/rspe_genbuild.sv -----
// ----------------------------------------------------------------------------
// rspe_genbuild
// Builds the generator polynomial one root per cycle after reset or after a
// parity count write.
// ----------------------------------------------------------------------------
module rspe_genbuild import rspe_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             cfg_wr,
   input  logic [CFG_W-1:0] cfg_value,
   output gen_stat_type     gen_stat,
   output coef_vec_type     coef
);

   coef_vec_type     poly_ff, poly_in;
   gf_byte_type      root_ff;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] step_ff, step_in;
   logic             busy_ff;

   // Multiply the running product by (x - root); subtraction is XOR here.
   always_comb begin
      poly_in[0] = gf_mul(poly_ff[0], root_ff);
      for (int j = 1; j < MAX_PARITY; j++) begin
         poly_in[j] = poly_ff[j-1] ^ gf_mul(poly_ff[j], root_ff);
      end
      step_in = step_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset || cfg_wr) begin
         count_ff <= reset ? CNT_W'(RESET_PARITY) : clamp_count(cfg_value);
         busy_ff  <= 1'b1;
         step_ff  <= '0;
         root_ff  <= GF_ONE;
         poly_ff  <= {{(MAX_PARITY-1){8'h00}}, GF_ONE};
      end else if (busy_ff) begin
         poly_ff <= poly_in;
         root_ff <= gf_mul(root_ff, GF_ALPHA);
         step_ff <= step_in;
         if (step_in == count_ff) begin
            busy_ff <= 1'b0;
         end
      end
   end

   assign gen_stat.busy  = busy_ff;
   assign gen_stat.count = count_ff;
   assign coef           = poly_ff;

endmodule

// ----- hdl/rspe_div.sv -----
// ----------------------------------------------------------------------------
// rspe_div
// Polynomial division register: absorbs one data byte per cycle unless held
// back, and hands the remainder to the output stage at the end of a block.
// ----------------------------------------------------------------------------
module rspe_div import rspe_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          cfg_wr,
   input  gen_stat_type  gen_stat,
   input  coef_vec_type  coef,
   input  logic          q_valid,
   input  item_type      q_item,
   output logic          q_pop,
   input  logic          emit_free,
   output emit_load_type emit_load,
   output coef_vec_type  snap
);

   // Stage j holds the remainder coefficient of degree j; the feedback tap
   // is the top stage in use, which moves with the parity count.
   coef_vec_type     rem_ff, rem_in;
   logic [IDX_W-1:0] top_idx;
   gf_byte_type      fb;
   logic             absorb;

   assign top_idx = IDX_W'(gen_stat.count - 1'b1);
   assign fb      = q_item.data_byte ^ rem_ff[top_idx];

   always_comb begin
      rem_in[0] = gf_mul(coef[0], fb);
      for (int j = 1; j < MAX_PARITY; j++) begin
         rem_in[j] = rem_ff[j-1] ^ gf_mul(coef[j], fb);
      end
   end

   // A final byte waits until the output stage can take the remainder.
   assign absorb = q_valid && !gen_stat.busy && !cfg_wr &&
                   (!q_item.block_end || emit_free);

   assign q_pop                = absorb;
   assign emit_load.load       = absorb && q_item.block_end;
   assign emit_load.last_index = top_idx;
   assign snap                 = rem_in;

   always_ff @(posedge clock) begin
      if (reset || cfg_wr) begin
         rem_ff <= '0;
      end else if (absorb) begin
         rem_ff <= q_item.block_end ? '0 : rem_in;
      end
   end

endmodule

// ----- hdl/rspe_emit.sv -----
// ----------------------------------------------------------------------------
// rspe_emit
// Output stage: holds one block's remainder and sends it highest degree
// first on the result channel.
// ----------------------------------------------------------------------------
module rspe_emit import rspe_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  emit_load_type emit_load,
   input  coef_vec_type  snap,
   output logic          emit_free,
   rspe_rsp_if.source    rsp_chan
);

   coef_vec_type     par_ff;
   logic [IDX_W-1:0] idx_ff;
   logic             busy_ff;
   logic             take;
   logic             at_last;

   assign at_last   = (idx_ff == '0);
   assign take      = busy_ff && rsp_chan.ready;
   assign emit_free = !busy_ff || (rsp_chan.ready && at_last);

   assign rsp_chan.valid       = busy_ff;
   assign rsp_chan.parity_byte = par_ff[idx_ff];
   assign rsp_chan.parity_last = at_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else if (emit_load.load) begin
         busy_ff <= 1'b1;
         idx_ff  <= emit_load.last_index;
      end else if (take) begin
         if (at_last) begin
            busy_ff <= 1'b0;
         end else begin
            idx_ff <= idx_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit_load.load) begin
         par_ff <= snap;
      end
   end

endmodule

// ----- hdl/rspe_checker.sv -----
// ----------------------------------------------------------------------------
// rspe_checker
// Port-level checks for the Reed-Solomon parity encoder, bound to the top.
// ----------------------------------------------------------------------------
module rspe_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] parity_byte,
   input logic       parity_last
);

   // A stalled result holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(parity_byte) && $stable(parity_last))
      else $error("parity result changed while stalled");

   // The parity bytes of a block leave without a gap once the sink takes them.
   a_rsp_burst: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !parity_last |=> rsp_valid)
      else $error("gap inside a parity burst");

   // Reset leaves no parity pending.
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("parity result valid after reset");

   // Reset leaves the request queue empty and open.
   a_req_reset: assert property (@(posedge clock)
      reset |=> req_ready)
      else $error("request channel not ready after reset");

endmodule

bind reed_solomon_parity_encoder rspe_checker u_rspe_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .parity_byte (rsp_chan.parity_byte),
   .parity_last (rsp_chan.parity_last)
);
